FILE: hdl/mbpscan_pkg.sv
// Shared constants and types of the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbpscan_pkg;

  // Payload and register widths
  localparam int unsigned DATA_W            = 8;
  localparam int unsigned PATTERN_REG_BYTES = 16;
  localparam int unsigned PATTERN_W         = 64;
  localparam int unsigned CARE_W            = 16;
  localparam int unsigned LENGTH_W          = 5;
  localparam int unsigned COUNT_W           = 32;
  localparam int unsigned OFFSET_W          = 32;
  localparam int unsigned MATCH_W           = 32;

  // Configuration port
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_MAX_HITS     = 3'd4,
    REG_START_OFFSET = 3'd5
  } cfg_reg_t;

endpackage

FILE: hdl/mbpscan_if.sv
// Valid/ready channel interfaces for the scanner's byte input and result output.
`timescale 1ns / 1ps

interface mbpscan_in_if
  import mbpscan_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface mbpscan_out_if
  import mbpscan_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MATCH_W-1:0] match_start;
  logic               found;
  logic               search_done;

  modport source (output valid, output match_start, output found, output search_done,
                  input ready);
  modport sink   (input valid, input match_start, input found, input search_done,
                  output ready);
endinterface

FILE: hdl/masked_byte_pattern_scanner_core.sv
// Masked byte pattern scanner: top level with window compare and result register.
`timescale 1ns / 1ps

// One byte word is taken per clock cycle when the result side keeps ready high;
// each word is captured in an input register, and its result word, if any, is
// written to the result register once that register is free. The rate is set
// by the window compare, which checks all pattern bytes against the held
// history and the new byte in parallel and combinationally. A result word
// is produced for a byte that completes a reportable matching window, or for
// the byte flagged buffer_end (search_done set); other bytes give no word. The
// history, the position counter and the hit counter clear after the final
// byte of each buffer. Configuration writes take effect from the next byte.
module masked_byte_pattern_scanner_core
  import mbpscan_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned POSITION_BITS     = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  mbpscan_in_if.sink             in_ch,
  mbpscan_out_if.source          out_ch,
  input  logic                   write_en,
  input  logic [CFG_INDEX_W-1:0] reg_index,
  input  logic [CFG_DATA_W-1:0]  write_data
);

  localparam int unsigned HIST_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
  localparam int unsigned HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned LEN_W      = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned CMP_W      = ((LEN_W > LENGTH_W) ? LEN_W : LENGTH_W) + 1;
  localparam int unsigned ST_W       = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

  // Configuration registers
  logic [PATTERN_W-1:0] pattern_low;
  logic [PATTERN_W-1:0] pattern_high;
  logic [CARE_W-1:0]    care_mask;
  logic [LENGTH_W-1:0]  pattern_length;
  logic [COUNT_W-1:0]   max_hits;
  logic [OFFSET_W-1:0]  start_offset;

  // Input stage
  logic              s1_valid;
  logic [DATA_W-1:0] s1_byte;
  logic              s1_last;

  // Buffer state
  logic [DATA_W-1:0]        hist [HIST_DEPTH];
  logic [POSITION_BITS-1:0] byte_position;
  logic [COUNT_W-1:0]       hit_count;
  logic                     hits_exhausted;

  // Result register
  logic               o_valid;
  logic [MATCH_W-1:0] o_match_start;
  logic               o_found;
  logic               o_done;

  logic                     out_free;
  logic                     s1_adv;
  logic [LEN_W-1:0]         eff_len;
  logic [POSITION_BITS-1:0] len_m1;
  logic [POSITION_BITS-1:0] win_start;
  logic [ST_W-1:0]          win_start_ext;
  logic                     window_full;
  logic                     offset_ok;
  logic                     exh_now;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                     hit;
  logic [COUNT_W-1:0]       hit_count_next;
  logic                     hits_exhausted_next;
  logic [2*PATTERN_W-1:0]   pattern_all;

  // Handshake: the input stage moves on whenever the result register is free
  assign out_free    = !o_valid || out_ch.ready;
  assign s1_adv      = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;

  assign out_ch.valid       = o_valid;
  assign out_ch.match_start = o_match_start;
  assign out_ch.found       = o_found;
  assign out_ch.search_done = o_done;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= LENGTH_W'(1);
      max_hits       <= '0;
      start_offset   <= '0;
    end else if (write_en) begin
      unique case (cfg_reg_t'(reg_index))
        REG_PATTERN_LOW:  pattern_low    <= write_data;
        REG_PATTERN_HIGH: pattern_high   <= write_data;
        REG_CARE_MASK:    care_mask      <= write_data[CARE_W-1:0];
        REG_PATTERN_LEN:  pattern_length <= write_data[LENGTH_W-1:0];
        REG_MAX_HITS:     max_hits       <= write_data[COUNT_W-1:0];
        REG_START_OFFSET: start_offset   <= write_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.data_byte;
      s1_last <= in_ch.buffer_end;
    end
  end

  // Effective pattern length, clamped to 1..MAX_PATTERN_BYTES
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (CMP_W'(pattern_length) > CMP_W'(MAX_PATTERN_BYTES)) begin
      eff_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  assign pattern_all = {pattern_high, pattern_low};

  // Per-byte compare; pattern byte j meets the byte eff_len-1-j words back
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cmp
    if (j < PATTERN_REG_BYTES) begin : g_reg
      logic [LEN_W-1:0]  back;
      logic [HIDX_W-1:0] hidx;
      logic [DATA_W-1:0] have;
      logic              active;

      assign back   = eff_len - LEN_W'(j + 1);
      assign hidx   = HIDX_W'(back - LEN_W'(1));
      assign have   = (back == '0) ? s1_byte : hist[hidx];
      assign active = (LEN_W'(j) < eff_len) && care_mask[j];
      assign byte_ok[j] = !active || (have == pattern_all[DATA_W*j +: DATA_W]);
    end else begin : g_wild
      // no pattern register behind this position: always a wildcard
      assign byte_ok[j] = 1'b1;
    end
  end

  // Window position, hit limit and offset checks
  assign len_m1        = POSITION_BITS'(eff_len - LEN_W'(1));
  assign window_full   = byte_position >= len_m1;
  assign win_start     = byte_position - len_m1;
  assign win_start_ext = ST_W'(win_start);
  assign offset_ok     = win_start_ext >= ST_W'(start_offset);
  assign exh_now       = hits_exhausted || ((max_hits != '0) && (hit_count >= max_hits));
  assign hit           = window_full && !exh_now && offset_ok && (&byte_ok);

  always_comb begin
    hit_count_next = hit_count;
    if (hit && (hit_count != '1)) begin
      hit_count_next = hit_count + COUNT_W'(1);
    end
    hits_exhausted_next = exh_now ||
                          (hit && (max_hits != '0) && (hit_count_next >= max_hits));
  end

  // Buffer state update, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      hit_count      <= '0;
      hits_exhausted <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last) begin
        byte_position  <= '0;
        hit_count      <= '0;
        hits_exhausted <= 1'b0;
      end else begin
        if (byte_position != '1) begin
          byte_position <= byte_position + POSITION_BITS'(1);
        end
        hit_count      <= hit_count_next;
        hits_exhausted <= hits_exhausted_next;
      end
    end
  end

  // History shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist[k] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_last) begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
          hist[k] <= '0;
        end
      end else begin
        hist[0] <= s1_byte;
        for (int k = 1; k < HIST_DEPTH; k++) begin
          hist[k] <= hist[k-1];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv && (hit || s1_last)) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (hit || s1_last)) begin
      o_match_start <= hit ? win_start_ext[MATCH_W-1:0] : '0;
      o_found       <= hit;
      o_done        <= s1_last;
    end
  end

endmodule

FILE: hdl/mbpscan_checker.sv
// Port-level checks on the scanner's result channel, bound to the top level.
`timescale 1ns / 1ps

module mbpscan_checker
  import mbpscan_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MATCH_W-1:0] match_start,
  input logic               found,
  input logic               search_done
);

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_start) &&
    $stable(found) && $stable(search_done))
    else $error("result word changed while stalled");

  // every word carries a hit or the end of a buffer
  a_word_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> found || search_done)
    else $error("result word with neither hit nor end of buffer");

  // a word without a hit shows position zero
  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_start == '0)
    else $error("match_start nonzero without a hit");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind masked_byte_pattern_scanner_core mbpscan_checker u_mbpscan_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .match_start (out_ch.match_start),
  .found       (out_ch.found),
  .search_done (out_ch.search_done)
);
